### sv/vwt_pkg.sv
// shared types and constants for the vertex weld table
`timescale 1ns / 1ps

package vwt_pkg;

	localparam int MAX_VERTICES = 1024;
	localparam int INDEX_W = $clog2(MAX_VERTICES);
	localparam int COUNT_W = INDEX_W + 1;
	localparam int COORD_W = 32;
	localparam int KEY_W = 64;
	localparam int VIDX_W = 10;
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W = QPTR_W + 1;
	localparam logic [31:0] INV_TOL_RESET = 32'd65536;

	typedef struct packed {
		logic signed [COORD_W-1:0] x_coord;
		logic signed [COORD_W-1:0] y_coord;
		logic signed [COORD_W-1:0] z_coord;
	} vwt_vertex_t;

	typedef struct packed {
		logic [VIDX_W-1:0] vertex_index;
		logic              is_new;
		logic              table_full;
	} vwt_result_t;

	typedef struct packed {
		logic             valid;
		logic [KEY_W-1:0] key;
	} vwt_key_xfer_t;

	typedef enum logic [3:0] {
		F_IDLE,
		F_QX,
		F_QY,
		F_QZ,
		F_QW,
		F_SUM,
		F_M0,
		F_M1,
		F_M2,
		F_M3,
		F_ADD,
		F_PUSH
	} vwt_front_state_t;

	typedef enum logic [1:0] {
		B_IDLE,
		B_SCAN,
		B_EMIT
	} vwt_back_state_t;

endpackage

### sv/vwt_front.sv
// front end: quantizes a vertex and builds its pairing key on one shared multiplier
`timescale 1ns / 1ps

module vwt_front import vwt_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic [31:0]   inv_tol,
	input  logic          vertex_valid,
	output logic          vertex_stall,
	input  vwt_vertex_t   vertex,
	output vwt_key_xfer_t push,
	input  logic          push_ready
);

	function automatic logic [COORD_W-1:0] coord_mag(input logic [COORD_W-1:0] raw);
		return raw[COORD_W-1] ? (~raw + COORD_W'(1)) : raw;
	endfunction

	function automatic logic [COORD_W-1:0] quant_fix(input logic [KEY_W-1:0] p,
			input logic neg);
		logic [COORD_W-1:0] q;
		q = p[KEY_W-1:COORD_W];
		return neg ? (~q + COORD_W'(1)) : q;
	endfunction

	vwt_front_state_t   st_q, st_d;
	vwt_vertex_t        vtx_q;
	logic [KEY_W-1:0]   prod_q;
	logic [COORD_W-1:0] qx_q, qy_q;
	logic [KEY_W-1:0]   ca_q, cb_q, h_q, m_q, acc_q, key_q;
	logic               outer_q;
	logic [31:0]        mul_a, mul_b;
	logic [KEY_W-1:0]   s_sum, t_sum, key_sum;

	assign s_sum = ca_q + cb_q;
	assign t_sum = s_sum + KEY_W'(1);
	assign key_sum = acc_q + cb_q;

	always_comb begin
		st_d = st_q;
		mul_a = '0;
		mul_b = '0;
		unique case (st_q)
			F_IDLE: begin
				if (vertex_valid) st_d = F_QX;
			end
			F_QX: begin
				mul_a = coord_mag(vtx_q.x_coord);
				mul_b = inv_tol;
				st_d = F_QY;
			end
			F_QY: begin
				mul_a = coord_mag(vtx_q.y_coord);
				mul_b = inv_tol;
				st_d = F_QZ;
			end
			F_QZ: begin
				mul_a = coord_mag(vtx_q.z_coord);
				mul_b = inv_tol;
				st_d = F_QW;
			end
			F_QW: st_d = F_SUM;
			F_SUM: st_d = F_M0;
			F_M0: begin
				mul_a = h_q[31:0];
				mul_b = m_q[31:0];
				st_d = F_M1;
			end
			F_M1: begin
				mul_a = h_q[63:32];
				mul_b = m_q[31:0];
				st_d = F_M2;
			end
			F_M2: begin
				mul_a = h_q[31:0];
				mul_b = m_q[63:32];
				st_d = F_M3;
			end
			F_M3: st_d = F_ADD;
			F_ADD: st_d = outer_q ? F_PUSH : F_SUM;
			F_PUSH: begin
				if (push_ready) st_d = F_IDLE;
			end
			default: st_d = F_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= F_IDLE;
		end else begin
			st_q <= st_d;
		end
	end

	// datapath, no reset needed
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		case (st_q)
			F_IDLE: begin
				if (vertex_valid) vtx_q <= vertex;
			end
			F_QY: qx_q <= quant_fix(prod_q, vtx_q.x_coord[COORD_W-1]);
			F_QZ: qy_q <= quant_fix(prod_q, vtx_q.y_coord[COORD_W-1]);
			F_QW: begin
				ca_q <= KEY_W'(qy_q);
				cb_q <= KEY_W'(quant_fix(prod_q, vtx_q.z_coord[COORD_W-1]));
				outer_q <= 1'b0;
			end
			F_SUM: begin
				// halve the even factor of s*(s+1)
				if (!s_sum[0]) begin
					h_q <= s_sum >> 1;
					m_q <= t_sum;
				end else begin
					h_q <= s_sum;
					m_q <= t_sum >> 1;
				end
			end
			F_M1: acc_q <= prod_q;
			F_M2: acc_q <= acc_q + {prod_q[31:0], 32'd0};
			F_M3: acc_q <= acc_q + {prod_q[31:0], 32'd0};
			F_ADD: begin
				if (!outer_q) begin
					ca_q <= KEY_W'(qx_q);
					cb_q <= key_sum;
					outer_q <= 1'b1;
				end else begin
					key_q <= key_sum;
				end
			end
			default: ;
		endcase
	end

	assign vertex_stall = (st_q != F_IDLE);
	assign push.valid = (st_q == F_PUSH);
	assign push.key = key_q;

endmodule

### sv/vwt_queue.sv
// short key queue between the front end and the table search
`timescale 1ns / 1ps

module vwt_queue import vwt_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  vwt_key_xfer_t push,
	output logic          push_ready,
	output logic          pop_valid,
	output logic [KEY_W-1:0] pop_key,
	input  logic          pop
);

	logic [KEY_W-1:0]  slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              do_push, do_pop;

	assign push_ready = (cnt_q != QCNT_W'(QUEUE_DEPTH));
	assign pop_valid = (cnt_q != '0);
	assign pop_key = slot_q[rd_ptr_q];
	assign do_push = push.valid && push_ready;
	assign do_pop = pop && pop_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			if (do_pop) rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			if (do_push && !do_pop) cnt_q <= cnt_q + QCNT_W'(1);
			else if (do_pop && !do_push) cnt_q <= cnt_q - QCNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) slot_q[wr_ptr_q] <= push.key;
	end

endmodule

### sv/vwt_back.sv
// back end: scans the key memory, appends new keys and holds the result
`timescale 1ns / 1ps

module vwt_back import vwt_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             pop_valid,
	input  logic [KEY_W-1:0] pop_key,
	output logic             pop,
	output logic             result_valid,
	input  logic             result_stall,
	output vwt_result_t      result
);

	logic [KEY_W-1:0]   key_mem [MAX_VERTICES];

	vwt_back_state_t    st_q, st_d;
	logic [KEY_W-1:0]   key_q;
	logic [COUNT_W-1:0] count_q;
	logic [COUNT_W-1:0] issue_q;
	logic               vld_s1;
	logic [INDEX_W-1:0] idx_s1;
	logic [KEY_W-1:0]   rd_data_s1;
	vwt_result_t        pend_q, pend_d;
	logic               res_valid_q;
	vwt_result_t        res_q;
	logic               more, issuing, hit, miss, room, store, out_free;

	assign more = (issue_q < count_q);
	assign issuing = (st_q == B_SCAN) && more;
	assign hit = (st_q == B_SCAN) && vld_s1 && (rd_data_s1 == key_q);
	assign miss = (st_q == B_SCAN) && !vld_s1 && !more;
	assign room = (count_q < COUNT_W'(MAX_VERTICES));
	assign store = miss && room;
	assign out_free = !res_valid_q || !result_stall;

	always_comb begin
		st_d = st_q;
		pop = 1'b0;
		pend_d = pend_q;
		unique case (st_q)
			B_IDLE: begin
				if (pop_valid) begin
					pop = 1'b1;
					st_d = B_SCAN;
				end
			end
			B_SCAN: begin
				if (hit) begin
					pend_d.vertex_index = VIDX_W'(idx_s1);
					pend_d.is_new = 1'b0;
					pend_d.table_full = 1'b0;
					st_d = B_EMIT;
				end else if (miss) begin
					pend_d.vertex_index = room ? VIDX_W'(count_q[INDEX_W-1:0]) : '0;
					pend_d.is_new = room;
					pend_d.table_full = !room;
					st_d = B_EMIT;
				end
			end
			B_EMIT: begin
				if (out_free) st_d = B_IDLE;
			end
			default: st_d = B_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= B_IDLE;
			count_q <= '0;
			vld_s1 <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			st_q <= st_d;
			vld_s1 <= issuing;
			if (store) count_q <= count_q + COUNT_W'(1);
			if (st_q == B_EMIT && out_free) res_valid_q <= 1'b1;
			else if (!result_stall) res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		pend_q <= pend_d;
		idx_s1 <= issue_q[INDEX_W-1:0];
		if (st_q == B_IDLE) begin
			key_q <= pop_key;
			issue_q <= '0;
		end else if (issuing) begin
			issue_q <= issue_q + COUNT_W'(1);
		end
		if (st_q == B_EMIT && out_free) res_q <= pend_q;
	end

	// key memory: one read and one write port
	always_ff @(posedge clk) begin
		rd_data_s1 <= key_mem[issue_q[INDEX_W-1:0]];
		if (store) key_mem[count_q[INDEX_W-1:0]] <= key_q;
	end

	assign result_valid = res_valid_q;
	assign result = res_q;

endmodule

### sv/vertex_weld_table.sv
// top level of the vertex weld table
//
// vertices come in on the vertex channel (valid/stall) as signed Q16.16
// x, y, z. each is scaled by inv_tolerance, truncated toward zero and folded
// into a 64-bit key by nested cantor pairing. the key is searched in a
// 1024-entry key memory; a hit returns the stored index, a miss appends the
// key (is_new) or, with the memory full, returns index 0 with table_full.
// one result per vertex leaves on the result channel (valid/stall).
// the front end quantizes and pairs each vertex on its one 32x32 multiplier
// and takes no new vertex until it has pushed the key into a two-entry
// queue; it can work on the next vertex while the back end searches. the
// search reads one stored key per cycle from the memory read port, so its
// time grows with the number of stored entries.
// a stalled result stays in the output register while the next vertex is
// already taken and searched; the search waits only when it has a result
// and the register is still full.
// reset empties the table (entry count zero, no clearing pass) and sets
// inv_tolerance to 1.0. cfg_ready is always high; write it only when idle.
`timescale 1ns / 1ps

module vertex_weld_table import vwt_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        vertex_valid,
	output logic        vertex_stall,
	input  vwt_vertex_t vertex,
	output logic        result_valid,
	input  logic        result_stall,
	output vwt_result_t result,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [31:0] cfg_data
);

	logic [31:0]      inv_tol_q;
	vwt_key_xfer_t    push;
	logic             push_ready;
	logic             pop_valid, pop;
	logic [KEY_W-1:0] pop_key;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inv_tol_q <= INV_TOL_RESET;
		end else if (cfg_valid && cfg_ready) begin
			inv_tol_q <= cfg_data;
		end
	end

	vwt_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.inv_tol      (inv_tol_q),
		.vertex_valid (vertex_valid),
		.vertex_stall (vertex_stall),
		.vertex       (vertex),
		.push         (push),
		.push_ready   (push_ready)
	);

	vwt_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_ready (push_ready),
		.pop_valid  (pop_valid),
		.pop_key    (pop_key),
		.pop        (pop)
	);

	vwt_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.pop_valid    (pop_valid),
		.pop_key      (pop_key),
		.pop          (pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule

### sv/vwt_checker.sv
// port checker for the vertex weld table, bound to the top level
`timescale 1ns / 1ps

module vwt_checker import vwt_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        vertex_valid,
	input logic        vertex_stall,
	input logic        result_valid,
	input logic        result_stall,
	input vwt_result_t result
);

	// stalled result transaction holds
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("result changed while stalled");

	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> !(result.is_new && result.table_full))
		else $error("is_new and table_full both set");

	a_full_index_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.table_full |-> result.vertex_index == '0)
		else $error("table_full with nonzero index");

	// front end is busy after taking a vertex
	a_front_busy: assert property (@(posedge clk) disable iff (!arst_n)
		vertex_valid && !vertex_stall |=> vertex_stall)
		else $error("vertex accepted on back-to-back cycles");

endmodule

bind vertex_weld_table vwt_checker u_vwt_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.vertex_valid (vertex_valid),
	.vertex_stall (vertex_stall),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result       (result)
);
